// ===== rtl/core/clcd_pkg.sv =====
package clcd_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] ModeCommand = 2'd0;
  localparam logic [1:0] ModeChar    = 2'd1;
  localparam logic [1:0] ModeStartup = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] RegEnablePulse = 3'd0;
  localparam logic [2:0] RegGap         = 3'd1;
  localparam logic [2:0] RegPowerUp     = 3'd2;
  localparam logic [2:0] RegClearWait   = 3'd3;
  localparam logic [2:0] RegFuncSetWait = 3'd4;
  localparam logic [2:0] RegDispOnWait  = 3'd5;

  localparam int unsigned CycW  = 20;
  localparam int unsigned StepW = 5;

  // Highest phase index of the start-up run
  localparam logic [StepW-1:0] LastStep = 5'd18;

  // Reset values of the configuration registers
  localparam logic [CycW-1:0] EnablePulseRst = 20'd16000;
  localparam logic [CycW-1:0] GapRst         = 20'd1;
  localparam logic [CycW-1:0] PowerUpRst     = 20'd560000;
  localparam logic [CycW-1:0] ClearWaitRst   = 20'd32000;
  localparam logic [CycW-1:0] FuncSetWaitRst = 20'd720000;
  localparam logic [CycW-1:0] DispOnWaitRst  = 20'd720;

  // Start-up nibble and command bytes
  localparam logic [3:0] InitNibble   = 4'b0010;
  localparam logic [7:0] CmdFuncSet   = 8'b0010_1000;
  localparam logic [7:0] CmdDisplayOn = 8'b0000_1111;
  localparam logic [7:0] CmdClear     = 8'b0000_0001;
  localparam logic [7:0] CmdEntryMode = 8'b0000_0110;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SEND
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic             take_req;
    logic             build;
    logic [StepW-1:0] step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_ok;
    logic last;
  } dp_status_t;

endpackage

// ===== rtl/core/clcd_ctrl.sv =====
module clcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clcd_pkg::ctrl_cmd_t cmd_o,
  input  clcd_pkg::dp_status_t status_i
);
  import clcd_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.step   = step_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_req = 1'b1;
          step_d         = '0;
          // drop the unused request kind without a transfer on the output
          if (status_i.req_ok) begin
            state_d = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        cmd_o.build = 1'b1;
        state_d     = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = ST_IDLE;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_BUILD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStep)
    else $error("phase index beyond start-up run");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && !out_ready_i) |=> (state_q == ST_SEND && $stable(step_q)))
    else $error("phase lost under output stall");

  a_build_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUILD) |=> (state_q == ST_SEND))
    else $error("built phase not offered");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a phase is pending");

endmodule

// ===== rtl/core/clcd_dpath.sv =====
module clcd_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [clcd_pkg::CycW-1:0]  cfg_data_i,
  input  logic [1:0]                 in_mode_i,
  input  logic [7:0]                 in_byte_i,
  input  clcd_pkg::ctrl_cmd_t        cmd_i,
  output clcd_pkg::dp_status_t       status_o,
  output logic                       rs_o,
  output logic                       rw_o,
  output logic                       en_o,
  output logic [3:0]                 nibble_o,
  output logic [clcd_pkg::CycW-1:0]  hold_o,
  output logic                       last_o
);
  import clcd_pkg::*;

  logic [CycW-1:0] pulse_q, gap_q, pwr_q, clr_q, fset_q, don_q;
  logic [1:0]      mode_q;
  logic [7:0]      byte_q;
  logic            rs_q, en_q, last_q;
  logic [3:0]      nib_q;
  logic [CycW-1:0] hold_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= EnablePulseRst;
      gap_q   <= GapRst;
      pwr_q   <= PowerUpRst;
      clr_q   <= ClearWaitRst;
      fset_q  <= FuncSetWaitRst;
      don_q   <= DispOnWaitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegEnablePulse: pulse_q <= cfg_data_i;
        RegGap:         gap_q   <= cfg_data_i;
        RegPowerUp:     pwr_q   <= cfg_data_i;
        RegClearWait:   clr_q   <= cfg_data_i;
        RegFuncSetWait: fset_q  <= cfg_data_i;
        RegDispOnWait:  don_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CycW-1:0] pulse_len;
  logic [3:0]      sub_idx;
  logic [1:0]      sub;
  logic [1:0]      bsel;
  logic [7:0]      cur_byte;
  logic [CycW-1:0] final_hold;
  logic            byte_last;
  logic            rs_d, en_d, last_d;
  logic [3:0]      nib_d;
  logic [CycW-1:0] hold_d;

  assign pulse_len = (pulse_q == '0) ? CycW'(1) : pulse_q;

  always_comb begin
    // start-up bytes begin at phase three
    sub_idx    = 4'(cmd_i.step - StepW'(3));
    bsel       = sub_idx[3:2];
    sub        = (mode_q == ModeStartup) ? sub_idx[1:0] : cmd_i.step[1:0];
    cur_byte   = byte_q;
    final_hold = gap_q;
    byte_last  = 1'b1;
    if (mode_q == ModeStartup) begin
      byte_last = (bsel == 2'd3);
      case (bsel)
        2'd0: begin
          cur_byte   = CmdFuncSet;
          final_hold = fset_q;
        end
        2'd1: begin
          cur_byte   = CmdDisplayOn;
          final_hold = don_q;
        end
        2'd2: begin
          cur_byte   = CmdClear;
          final_hold = clr_q;
        end
        default: begin
          cur_byte   = CmdEntryMode;
          final_hold = gap_q;
        end
      endcase
    end else if (mode_q == ModeCommand && byte_q == CmdClear) begin
      final_hold = clr_q;
    end

    rs_d   = (mode_q == ModeChar);
    en_d   = 1'b0;
    nib_d  = cur_byte[7:4];
    hold_d = gap_q;
    last_d = 1'b0;
    case (sub)
      2'd0: begin
        en_d   = 1'b1;
        hold_d = pulse_len;
      end
      2'd1: ;
      2'd2: begin
        en_d   = 1'b1;
        nib_d  = cur_byte[3:0];
        hold_d = pulse_len;
      end
      default: begin
        nib_d  = cur_byte[3:0];
        hold_d = final_hold;
        last_d = byte_last;
      end
    endcase

    // power-up wait and the lone init nibble ahead of the start-up bytes
    if (mode_q == ModeStartup && cmd_i.step < StepW'(3)) begin
      last_d = 1'b0;
      case (cmd_i.step[1:0])
        2'd0: begin
          en_d   = 1'b0;
          nib_d  = 4'h0;
          hold_d = pwr_q;
        end
        2'd1: begin
          en_d   = 1'b1;
          nib_d  = InitNibble;
          hold_d = pulse_len;
        end
        default: begin
          en_d   = 1'b0;
          nib_d  = InitNibble;
          hold_d = gap_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      mode_q <= in_mode_i;
      byte_q <= in_byte_i;
    end
    if (cmd_i.build) begin
      rs_q   <= rs_d;
      en_q   <= en_d;
      nib_q  <= nib_d;
      hold_q <= hold_d;
      last_q <= last_d;
    end
  end

  assign status_o.req_ok = (in_mode_i != ModeUnused);
  assign status_o.last   = last_q;

  assign rs_o     = rs_q;
  assign rw_o     = 1'b0;
  assign en_o     = en_q;
  assign nibble_o = nib_q;
  assign hold_o   = hold_q;
  assign last_o   = last_q;

endmodule

// ===== rtl/core/char_lcd_nibble_write_sequencer_unit.sv =====
// Character LCD 4-bit write sequencer.
// Input stream: tuser carries the request kind (command byte, character
// byte, start-up run; the fourth code is taken and dropped), tdata the byte.
// Output stream: one transfer per pin phase, giving RS, RW, EN, the D7..D4
// nibble and the hold time in clock cycles; tlast marks the request's final
// phase. A byte yields four phases, the start-up run nineteen.
// Configuration: write channel with a 3-bit register index and 20-bit data,
// always ready; indexes beyond the six timing registers are ignored. Write
// only while no request is in progress.
// Timing: each phase is formed in a build state, registered, and then offered
// in a send state; a new request is taken only once the previous run's last
// phase has been transferred. The phase sequencer and its single output
// register set this pacing.
// Reset clears the sequencer and loads the timing registers with their
// defaults. While the receiver stalls the offered phase holds unchanged.
module char_lcd_nibble_write_sequencer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [clcd_pkg::CycW-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]                s_axis_tuser,  // [1:0] mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] reg_select, [1] read_write, [2] enable_line, [6:3] data_nibble,
  // [26:7] hold_cycles, [31:27] zero
  output logic [31:0]               m_axis_tdata,
  output logic                      m_axis_tlast   // last_phase
);
  import clcd_pkg::*;

  ctrl_cmd_t       cmd;
  dp_status_t      status;
  logic            rs, rw, en, last;
  logic [3:0]      nibble;
  logic [CycW-1:0] hold;

  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  clcd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_mode_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .rs_o        (rs),
    .rw_o        (rw),
    .en_o        (en),
    .nibble_o    (nibble),
    .hold_o      (hold),
    .last_o      (last)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {5'b0, hold, nibble, en, rw, rs};
  assign m_axis_tlast = last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import clcd_pkg::*;

  localparam logic [2:0] RegSpareFirst = 3'd6;
  localparam logic [2:0] RegSpareLast  = 3'd7;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerPhase = 25;
  localparam int unsigned RandomPhases  = 4;

  typedef enum int { TIMING_MIN, TIMING_MAX, TIMING_RANDOM } timing_style_e;

  // Output transfer as seen on the bus, tlast on top of tdata
  typedef struct packed {
    logic            last;
    logic [4:0]      pad;
    logic [CycW-1:0] hold;
    logic [3:0]      nibble;
    logic            en;
    logic            rw;
    logic            rs;
  } lcd_phase_t;

  class lcd_phase_board;
    logic [CycW-1:0] pulse_len;
    logic [CycW-1:0] gap_len;
    logic [CycW-1:0] power_up_len;
    logic [CycW-1:0] clear_wait_len;
    logic [CycW-1:0] func_set_wait_len;
    logic [CycW-1:0] disp_on_wait_len;
    lcd_phase_t      pending[$];
    int              mismatches;

    function new();
      pulse_len         = EnablePulseRst;
      gap_len           = GapRst;
      power_up_len      = PowerUpRst;
      clear_wait_len    = ClearWaitRst;
      func_set_wait_len = FuncSetWaitRst;
      disp_on_wait_len  = DispOnWaitRst;
      mismatches        = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CycW-1:0] val);
      case (idx)
        RegEnablePulse: pulse_len = val;
        RegGap:         gap_len = val;
        RegPowerUp:     power_up_len = val;
        RegClearWait:   clear_wait_len = val;
        RegFuncSetWait: func_set_wait_len = val;
        RegDispOnWait:  disp_on_wait_len = val;
        default: ;
      endcase
    endfunction

    // A zero pulse length still gives one cycle of EN high
    function logic [CycW-1:0] en_high();
      return (pulse_len == '0) ? CycW'(1) : pulse_len;
    endfunction

    function void push_phase(logic rs, logic en, logic [3:0] nib, logic [CycW-1:0] hold,
                             logic last);
      lcd_phase_t p;
      p.last   = last;
      p.pad    = '0;
      p.hold   = hold;
      p.nibble = nib;
      p.en     = en;
      p.rw     = 1'b0;
      p.rs     = rs;
      pending.push_back(p);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, logic [CycW-1:0] final_hold, logic last);
      push_phase(rs, 1'b1, b[7:4], en_high(), 1'b0);
      push_phase(rs, 1'b0, b[7:4], gap_len, 1'b0);
      push_phase(rs, 1'b1, b[3:0], en_high(), 1'b0);
      push_phase(rs, 1'b0, b[3:0], final_hold, last);
    endfunction

    function void note_request(logic [1:0] mode, logic [7:0] b);
      case (mode)
        ModeCommand: push_byte(1'b0, b, (b == CmdClear) ? clear_wait_len : gap_len, 1'b1);
        ModeChar:    push_byte(1'b1, b, gap_len, 1'b1);
        ModeStartup: begin
          push_phase(1'b0, 1'b0, 4'h0, power_up_len, 1'b0);
          push_phase(1'b0, 1'b1, InitNibble, en_high(), 1'b0);
          push_phase(1'b0, 1'b0, InitNibble, gap_len, 1'b0);
          push_byte(1'b0, CmdFuncSet, func_set_wait_len, 1'b0);
          push_byte(1'b0, CmdDisplayOn, disp_on_wait_len, 1'b0);
          push_byte(1'b0, CmdClear, clear_wait_len, 1'b0);
          push_byte(1'b0, CmdEntryMode, gap_len, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function string fmt(lcd_phase_t p);
      return $sformatf("rs=%b rw=%b en=%b nib=%h hold=%0d last=%b pad=%h",
                       p.rs, p.rw, p.en, p.nibble, p.hold, p.last, p.pad);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_phase(logic [31:0] data, logic last);
      lcd_phase_t got;
      lcd_phase_t exp;
      got = {last, data};
      if (pending.size() == 0) begin
        report({"unexpected phase: ", fmt(got)});
        return;
      end
      exp = pending.pop_front();
      if (got.rs !== exp.rs || got.rw !== exp.rw || got.en !== exp.en ||
          got.nibble !== exp.nibble || got.hold !== exp.hold ||
          got.last !== exp.last || got.pad !== exp.pad)
        report({"phase mismatch: expected ", fmt(exp), " got ", fmt(got)});
    endfunction

    function void flush_leftover();
      while (pending.size() != 0) report({"missing phase: ", fmt(pending.pop_front())});
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i   = '0;
  logic [CycW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tlast;

  lcd_phase_board board;
  bit idle_on     = 1'b1;
  int rx_hold_off = 0;
  int rx_stretch  = 0;
  int quiet_cycles = 0;

  char_lcd_nibble_write_sequencer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: check each output transfer, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_phase(m_axis_tdata, m_axis_tlast);
    if (rx_hold_off > 0) begin
      rx_hold_off--;
      m_axis_tready <= 1'b0;
    end else if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stretch > 0) begin
      rx_stretch--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      rx_stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(mode, b);
  endtask

  // Drop valid and let the block run dry before touching its registers
  task automatic wait_block_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [CycW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
  endtask

  function logic [CycW-1:0] rand_timing();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return CycW'(1);
      2:       return '1;
      3, 4, 5: return CycW'($urandom_range(0, 255));
      default: return CycW'($urandom);
    endcase
  endfunction

  task automatic load_timing(input timing_style_e style);
    logic [CycW-1:0] val;
    for (int r = RegEnablePulse; r <= RegDispOnWait; r++) begin
      case (style)
        TIMING_MIN: val = '0;
        TIMING_MAX: val = '1;
        default:    val = rand_timing();
      endcase
      write_cfg(r[2:0], val);
    end
    // a write to a spare index must leave every register alone
    write_cfg(3'($urandom_range(RegSpareFirst, RegSpareLast)), CycW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit pressure);
    int n;
    int r;
    logic [1:0] mode;
    logic [7:0] b;
    n = 0;
    while (n < count) begin
      if (pressure && n == count / 3) rx_hold_off = HoldOffCycles;
      if (pressure && n == (2 * count) / 3) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (board.pending.size() != 0);
      end
      r = $urandom_range(0, 99);
      b = 8'($urandom);
      if (r < 8) mode = ModeStartup;
      else if (r < 12) mode = ModeUnused;
      else if (r < 20) begin
        mode = ModeCommand;
        b = CmdClear;
      end else if (r < 55) mode = ModeCommand;
      else mode = ModeChar;
      send_request(mode, b);
      if (mode != ModeUnused) n++;
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing values
    send_request(ModeStartup, 8'h00);
    send_request(ModeCommand, CmdClear);
    send_request(ModeCommand, 8'hFF);
    send_request(ModeChar, 8'h00);
    send_request(ModeUnused, 8'h5A);
    send_request(ModeChar, 8'hA5);
    wait_block_idle();

    // all registers at zero, enable pulse included
    load_timing(TIMING_MIN);
    send_request(ModeStartup, 8'hFF);
    send_request(ModeCommand, CmdClear);
    send_request(ModeChar, 8'hFF);
    send_request(ModeCommand, 8'h00);
    send_request(ModeUnused, 8'hFF);
    send_request(ModeChar, 8'h01);
    wait_block_idle();

    load_timing(TIMING_MAX);
    send_request(ModeStartup, 8'h5A);
    send_request(ModeCommand, CmdClear);
    send_request(ModeChar, 8'h5A);
    send_request(ModeCommand, 8'h80);
    send_request(ModeUnused, 8'h00);
    wait_block_idle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      load_timing(TIMING_RANDOM);
      idle_on = (ph != 1);
      run_random(ItemsPerPhase, ph == 2);
      wait_block_idle();
    end

    board.flush_leftover();
    if (board.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
